// ===== design/pidfd_pkg.sv =====
// Shared types, constants and saturation helpers for the filtered-derivative PID core.
package pidfd_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int OPND_W     = DATA_WIDTH + 1;
	localparam int PROD_W     = 2 * OPND_W;
	localparam int SUM_W      = DATA_WIDTH + 2;
	localparam int SHIFT_W    = PROD_W - FRAC_BITS;
	localparam int CFG_IDX_W  = 4;

	typedef logic signed [DATA_WIDTH-1:0] word_t;
	typedef logic [DATA_WIDTH-2:0]        weight_t;
	typedef logic signed [OPND_W-1:0]     opnd_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [SUM_W-1:0]      sum_t;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_P_GAIN      = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_I_GAIN      = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_D_GAIN      = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_POLE = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_SP_WEIGHT_P = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_SP_WEIGHT_D = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX   = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MIN   = CFG_IDX_W'(7);

	localparam word_t WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	// Reset values: pole of the derivative filter, unity proportional weight
	localparam longint POLE_RESET_I = -(((64'sd1 <<< FRAC_BITS) * 1999) / 2001);
	localparam word_t   POLE_RESET   = word_t'(POLE_RESET_I);
	localparam weight_t ONE_WEIGHT   = weight_t'(64'd1 << FRAC_BITS);

	// Extend a word to the exact-sum width
	function automatic sum_t sx(input word_t w);
		sx = {{(SUM_W-DATA_WIDTH){w[DATA_WIDTH-1]}}, w};
	endfunction

	// Saturate an exact sum to the word range
	function automatic word_t sat_sum(input sum_t s);
		logic top_ones;
		logic top_zeros;
		top_ones  = &s[SUM_W-1:DATA_WIDTH-1];
		top_zeros = ~|s[SUM_W-1:DATA_WIDTH-1];
		if (top_ones || top_zeros) begin
			sat_sum = s[DATA_WIDTH-1:0];
		end else begin
			sat_sum = s[SUM_W-1] ? WORD_MIN : WORD_MAX;
		end
	endfunction

	// Drop the fraction bits (floor) and saturate a product to the word range
	function automatic word_t sat_prod(input prod_t p);
		logic [SHIFT_W-1:0] s;
		logic top_ones;
		logic top_zeros;
		s         = p[PROD_W-1:FRAC_BITS];
		top_ones  = &s[SHIFT_W-1:DATA_WIDTH-1];
		top_zeros = ~|s[SHIFT_W-1:DATA_WIDTH-1];
		if (top_ones || top_zeros) begin
			sat_prod = s[DATA_WIDTH-1:0];
		end else begin
			sat_prod = s[SHIFT_W-1] ? WORD_MIN : WORD_MAX;
		end
	endfunction

endpackage

// ===== design/pid_filtered_derivative_controller_core.sv =====
// Top level of the two-degree-of-freedom PID core with filtered derivative.
// Each accepted word (reference, feedback) is worked through one shared
// 33x33 multiplier under an eight-step sequencer: six products (two setpoint
// weightings, proportional, integral, derivative and filter feedback) plus
// one step for the filter difference and one for the output sum, so an item
// occupies the core through all its steps after the accept cycle; the next
// item waits for idle. in_ready is high only while the sequencer is idle;
// a finished result waits in the output register and does not block the
// next accept, but the last step holds until that register is free.
// Configuration writes are taken every cycle and must only happen while idle.
module pid_filtered_derivative_controller_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [pidfd_pkg::DATA_WIDTH-1:0] reference,
	input  logic signed [pidfd_pkg::DATA_WIDTH-1:0] feedback,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [pidfd_pkg::DATA_WIDTH-1:0] drive,
	output logic                              clamped,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pidfd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pidfd_pkg::DATA_WIDTH-1:0]  cfg_data
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_M1   = 4'd1;
	localparam logic [3:0] ST_M2   = 4'd2;
	localparam logic [3:0] ST_M3   = 4'd3;
	localparam logic [3:0] ST_M4   = 4'd4;
	localparam logic [3:0] ST_M5   = 4'd5;
	localparam logic [3:0] ST_M6   = 4'd6;
	localparam logic [3:0] ST_M7   = 4'd7;
	localparam logic [3:0] ST_M8   = 4'd8;

	logic [3:0] state_q;

	pidfd_pkg::word_t   p_gain_q, i_gain_q, d_gain_q, pole_q, dmax_q, dmin_q;
	pidfd_pkg::weight_t swp_q, swd_q;
	pidfd_pkg::word_t   integ_q, prevw_q, prevf_q;
	pidfd_pkg::word_t   r_q, y_q, err_q, perr_q, derr_q, pterm_q, dterm_q;
	pidfd_pkg::sum_t    sum_q;
	pidfd_pkg::prod_t   prod_q;
	pidfd_pkg::opnd_t   mul_a, mul_b;
	pidfd_pkg::word_t   mq;
	pidfd_pkg::word_t   drive_q;
	logic               clamped_q, out_valid_q;
	logic               slot_free;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign clamped   = clamped_q;
	assign slot_free = !out_valid_q || out_ready;
	assign mq        = pidfd_pkg::sat_prod(prod_q);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_gain_q <= '0;
			i_gain_q <= '0;
			d_gain_q <= '0;
			pole_q   <= pidfd_pkg::POLE_RESET;
			swp_q    <= pidfd_pkg::ONE_WEIGHT;
			swd_q    <= '0;
			dmax_q   <= pidfd_pkg::WORD_MAX;
			dmin_q   <= pidfd_pkg::WORD_MIN;
		end else if (cfg_valid) begin
			case (cfg_index)
				pidfd_pkg::REG_P_GAIN:      p_gain_q <= cfg_data;
				pidfd_pkg::REG_I_GAIN:      i_gain_q <= cfg_data;
				pidfd_pkg::REG_D_GAIN:      d_gain_q <= cfg_data;
				pidfd_pkg::REG_FILTER_POLE: pole_q   <= cfg_data;
				pidfd_pkg::REG_SP_WEIGHT_P: swp_q    <= cfg_data[pidfd_pkg::DATA_WIDTH-2:0];
				pidfd_pkg::REG_SP_WEIGHT_D: swd_q    <= cfg_data[pidfd_pkg::DATA_WIDTH-2:0];
				pidfd_pkg::REG_DRIVE_MAX:   dmax_q   <= cfg_data;
				pidfd_pkg::REG_DRIVE_MIN:   dmin_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Select multiplier operands for the current step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_M1: begin
				mul_a = {2'b00, swp_q};
				mul_b = {r_q[pidfd_pkg::DATA_WIDTH-1], r_q};
			end
			ST_M2: begin
				mul_a = {2'b00, swd_q};
				mul_b = {r_q[pidfd_pkg::DATA_WIDTH-1], r_q};
			end
			ST_M3: begin
				mul_a = {p_gain_q[pidfd_pkg::DATA_WIDTH-1], p_gain_q};
				mul_b = {perr_q[pidfd_pkg::DATA_WIDTH-1], perr_q};
			end
			ST_M4: begin
				mul_a = {i_gain_q[pidfd_pkg::DATA_WIDTH-1], i_gain_q};
				mul_b = {err_q[pidfd_pkg::DATA_WIDTH-1], err_q};
			end
			ST_M5: begin
				mul_a = {d_gain_q[pidfd_pkg::DATA_WIDTH-1], d_gain_q};
				mul_b = {derr_q[pidfd_pkg::DATA_WIDTH-1], derr_q};
			end
			ST_M7: begin
				mul_a = {pole_q[pidfd_pkg::DATA_WIDTH-1], pole_q};
				mul_b = {dterm_q[pidfd_pkg::DATA_WIDTH-1], dterm_q};
			end
			default: ;
		endcase
	end

	// Register the shared product on multiply steps
	always_ff @(posedge clk) begin
		if (state_q inside {ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M7}) begin
			prod_q <= mul_a * mul_b;
		end
	end

	// Capture the input word and work the per-step differences and sums
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					r_q <= reference;
					y_q <= feedback;
				end
			end
			ST_M1: err_q   <= pidfd_pkg::sat_sum(pidfd_pkg::sx(r_q) - pidfd_pkg::sx(y_q));
			ST_M2: perr_q  <= pidfd_pkg::sat_sum(pidfd_pkg::sx(mq) - pidfd_pkg::sx(y_q));
			ST_M3: derr_q  <= pidfd_pkg::sat_sum(pidfd_pkg::sx(mq) - pidfd_pkg::sx(y_q));
			ST_M4: pterm_q <= mq;
			ST_M6: dterm_q <= pidfd_pkg::sat_sum(pidfd_pkg::sx(mq) - pidfd_pkg::sx(prevw_q)
			                                     - pidfd_pkg::sx(prevf_q));
			ST_M7: sum_q   <= pidfd_pkg::sx(pterm_q) + pidfd_pkg::sx(integ_q)
			                  + pidfd_pkg::sx(dterm_q);
			default: ;
		endcase
	end

	// Advance the sequencer and update controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			integ_q <= '0;
			prevw_q <= '0;
			prevf_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_M1;
					end
				end
				ST_M5: begin
					integ_q <= pidfd_pkg::sat_sum(pidfd_pkg::sx(integ_q) + pidfd_pkg::sx(mq));
					state_q <= ST_M6;
				end
				ST_M6: begin
					prevw_q <= mq;
					state_q <= ST_M7;
				end
				ST_M8: begin
					if (slot_free) begin
						prevf_q <= mq;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= state_q + 4'd1;
				end
			endcase
		end
	end

	// Clamp the sum into the output register; drop valid when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_M8 && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_M8 && slot_free) begin
			if (sum_q > pidfd_pkg::sx(dmax_q)) begin
				drive_q   <= dmax_q;
				clamped_q <= 1'b1;
			end else if (sum_q < pidfd_pkg::sx(dmin_q)) begin
				drive_q   <= dmin_q;
				clamped_q <= 1'b1;
			end else begin
				drive_q   <= sum_q[pidfd_pkg::DATA_WIDTH-1:0];
				clamped_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/pidfd_checker.sv =====
// Port-level checker for the PID core, bound to the top level.
module pidfd_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_valid,
	input logic                                   in_ready,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic signed [pidfd_pkg::DATA_WIDTH-1:0] drive,
	input logic                                   clamped
);

	// Hold a stalled result word
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(clamped))
		else $error("stalled result word changed");

	// Go busy after an accepted word
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input still ready after accept");

	// Deliver the result after an accept when the output was empty
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |-> ##9 out_valid)
		else $error("result word late");

	// Raise a result only out of a busy sequencer
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result word without work");

endmodule

bind pid_filtered_derivative_controller_core pidfd_checker u_pidfd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.drive     (drive),
	.clamped   (clamped)
);
